/* sv/ssp_pkg.sv */
package ssp_pkg;

  // sync byte that opens every status packet
  localparam logic [7:0] SyncByte = 8'hFF;

  // configuration register indexes
  localparam logic CfgTiltId = 1'b0;
  localparam logic CfgPanId  = 1'b1;

  // configuration reset values
  localparam logic [7:0] TiltIdReset = 8'd1;
  localparam logic [7:0] PanIdReset  = 8'd2;

  // axis codes
  localparam logic AxisPan  = 1'b0;
  localparam logic AxisTilt = 1'b1;

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PhSync1 = 7'b0000001,
    PhSync2 = 7'b0000010,
    PhId    = 7'b0000100,
    PhLen   = 7'b0001000,
    PhErr   = 7'b0010000,
    PhParam = 7'b0100000,
    PhCksum = 7'b1000000
  } ssp_phase_e;

  // one decoded position report
  typedef struct packed {
    logic        valid;
    logic        axis;
    logic [15:0] position;
  } ssp_result_t;

endpackage

/* sv/ssp_in_stage.sv */
module ssp_in_stage import ssp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       step_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // a held byte leaves whenever the parser advances
  assign ready_o = !valid_q || advance_i;
  assign step_o  = valid_q && advance_i;
  assign byte_o  = byte_q;

  // input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

/* sv/ssp_parser.sv */
module ssp_parser import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [7:0]  tilt_id_i,
  input  logic [7:0]  pan_id_i,
  output ssp_result_t result_o
);

  ssp_phase_e phase_q, phase_d;
  logic [7:0] id_q, id_d;
  logic [7:0] remaining_q, remaining_d;
  logic [1:0] seen_q, seen_d;
  logic [7:0] pos_lo_q, pos_lo_d;
  logic [7:0] pos_hi_q, pos_hi_d;
  logic [7:0] remaining_dec;
  logic       tilt_hit;
  logic       pan_hit;

  assign tilt_hit      = (id_q == tilt_id_i);
  assign pan_hit       = (id_q == pan_id_i);
  assign remaining_dec = (remaining_q != 8'd0) ? remaining_q - 8'd1 : 8'd0;

  // per-byte phase update
  always_comb begin
    phase_d     = phase_q;
    id_d        = id_q;
    remaining_d = remaining_q;
    seen_d      = seen_q;
    pos_lo_d    = pos_lo_q;
    pos_hi_d    = pos_hi_q;
    result_o    = '0;
    case (phase_q)
      PhSync1: begin
        if (byte_i == SyncByte) phase_d = PhSync2;
      end
      PhSync2: begin
        phase_d = (byte_i == SyncByte) ? PhId : PhSync1;
      end
      PhId: begin
        id_d    = byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        remaining_d = (byte_i >= 8'd2) ? byte_i - 8'd2 : 8'd0;
        seen_d      = 2'd0;
        phase_d     = PhErr;
      end
      PhErr: begin
        phase_d = (remaining_q != 8'd0) ? PhParam : PhCksum;
      end
      PhParam: begin
        if (seen_q == 2'd0) pos_lo_d = byte_i;
        if (seen_q == 2'd1) pos_hi_d = byte_i;
        if (seen_q < 2'd2) seen_d = seen_q + 2'd1;
        remaining_d = remaining_dec;
        if (remaining_dec == 8'd0) phase_d = PhCksum;
      end
      PhCksum: begin
        // checksum byte is dropped; report when the id is one of ours and at least two parameters came
        result_o.valid    = step_i && (seen_q >= 2'd2) && (tilt_hit || pan_hit);
        result_o.axis     = tilt_hit ? AxisTilt : AxisPan;
        result_o.position = {pos_hi_q, pos_lo_q};
        phase_d           = PhSync1;
      end
      default: begin
        phase_d = PhSync1;
      end
    endcase
  end

  // parser state, moves only on a byte step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSync1;
      id_q        <= 8'd0;
      remaining_q <= 8'd0;
      seen_q      <= 2'd0;
      pos_lo_q    <= 8'd0;
      pos_hi_q    <= 8'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      id_q        <= id_d;
      remaining_q <= remaining_d;
      seen_q      <= seen_d;
      pos_lo_q    <= pos_lo_d;
      pos_hi_q    <= pos_hi_d;
    end
  end

endmodule

/* sv/ssp_out_stage.sv */
module ssp_out_stage import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ssp_result_t result_i,
  output logic        advance_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        axis_o,
  output logic [15:0] position_o
);

  logic        valid_q;
  logic        axis_q;
  logic [15:0] position_q;

  // the register can load when empty or being drained this cycle
  assign advance_o  = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign axis_o     = axis_q;
  assign position_o = position_q;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      axis_q     <= result_i.axis;
      position_q <= result_i.position;
    end
  end

endmodule

/* sv/servo_status_packet_parser.sv */
// Servo status packet parser. Takes one received byte per beat on the slave
// stream, hunts for two 0xFF sync bytes, then reads id, length, error byte,
// length minus two parameter bytes and a checksum byte that is not checked.
// On the checksum byte of a packet whose id matches the tilt or pan id
// register and that carried at least two parameters, one beat leaves on the
// master stream: tdata is the little-endian position from the first two
// parameters, tuser the axis (1 tilt, 0 pan; tilt wins if both ids match).
// A byte passes an input register, the per-byte phase update and the result
// register; a new byte is taken every cycle while the result register is not
// held by a stalled master stream. The id registers (index 0 tilt, reset 1;
// index 1 pan, reset 2) are always ready and should be written only while no
// packet is in flight.
module servo_status_packet_parser import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // position reports
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] position
  output logic        m_axis_tuser,   // [0] axis
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic        advance;
  logic        step;
  logic [7:0]  step_byte;
  ssp_result_t result;
  logic [7:0]  tilt_id_q;
  logic [7:0]  pan_id_q;

  // id registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_id_q <= TiltIdReset;
      pan_id_q  <= PanIdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTiltId: tilt_id_q <= cfg_data_i;
        CfgPanId:  pan_id_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .byte_i    (s_axis_tdata),
    .advance_i (advance),
    .step_o    (step),
    .byte_o    (step_byte)
  );

  ssp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (step_byte),
    .tilt_id_i (tilt_id_q),
    .pan_id_i  (pan_id_q),
    .result_o  (result)
  );

  ssp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .result_i   (result),
    .advance_o  (advance),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .axis_o     (m_axis_tuser),
    .position_o (m_axis_tdata)
  );

endmodule

/* test/tb_servo_status_packet_parser.sv */
module tb_servo_status_packet_parser;
  import ssp_pkg::*;

  // one expected position report
  typedef struct packed {
    logic        axis;
    logic [15:0] position;
  } report_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = CfgTiltId;
  logic [7:0]  cfg_data_i    = 8'h00;

  servo_status_packet_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // bytes waiting to be sent and reports still owed by the block
  logic [7:0] rx_byte_q[$];
  report_t    pending_reports_q[$];

  // parser mirror: id registers and packet state
  logic [7:0] tilt_id = TiltIdReset;
  logic [7:0] pan_id  = PanIdReset;
  ssp_phase_e pp_phase = PhSync1;
  logic [7:0] pp_id = 8'h00;
  logic [7:0] pp_remaining = 8'h00;
  logic [1:0] pp_params = 2'd0;
  logic [7:0] pp_lo = 8'h00;
  logic [7:0] pp_hi = 8'h00;

  // idling controls, set per phase
  int src_gap_odds  = 0;
  int sink_gap_odds = 0;
  int src_gap       = 0;
  int sink_gap      = 0;
  int long_hold_asks = 0;
  int long_holds_done = 0;
  int hold_left     = 0;

  // run statistics
  int fail_count    = 0;
  int bytes_taken   = 0;
  int reports_seen  = 0;
  int tilt_reports  = 0;
  int id_settings   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d reports outstanding", pending_reports_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // advance the packet mirror by one received byte
  function void parse_rx_byte(input logic [7:0] b);
    report_t rpt;
    case (pp_phase)
      PhSync1: if (b == SyncByte) pp_phase = PhSync2;
      PhSync2: pp_phase = (b == SyncByte) ? PhId : PhSync1;
      PhId: begin
        pp_id    = b;
        pp_phase = PhLen;
      end
      PhLen: begin
        pp_remaining = (b >= 8'd2) ? b - 8'd2 : 8'd0;
        pp_params    = 2'd0;
        pp_phase     = PhErr;
      end
      PhErr: pp_phase = (pp_remaining != 8'd0) ? PhParam : PhCksum;
      PhParam: begin
        if (pp_params == 2'd0) pp_lo = b;
        else if (pp_params == 2'd1) pp_hi = b;
        if (pp_params < 2'd2) pp_params = pp_params + 2'd1;
        if (pp_remaining != 8'd0) pp_remaining = pp_remaining - 8'd1;
        if (pp_remaining == 8'd0) pp_phase = PhCksum;
      end
      PhCksum: begin
        // tilt wins when both ids match
        if (pp_params >= 2'd2 && (pp_id == tilt_id || pp_id == pan_id)) begin
          rpt.axis     = (pp_id == tilt_id) ? AxisTilt : AxisPan;
          rpt.position = {pp_hi, pp_lo};
          pending_reports_q.push_back(rpt);
        end
        pp_phase = PhSync1;
      end
      default: pp_phase = PhSync1;
    endcase
  endfunction

  // byte sender: predicts on each accepted beat, then offers the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_byte_q.pop_front();
          if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1)
            src_gap = $urandom_range(1, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // report receiver: checks each beat, stalls in bursts or one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    report_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (m_axis_tuser == AxisTilt) tilt_reports++;
        if (pending_reports_q.size() == 0) begin
          fail_count++;
          $display("%0t: report with none expected, got axis %0d position %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          exp = pending_reports_q.pop_front();
          if (m_axis_tuser !== exp.axis) begin
            fail_count++;
            $display("%0t: axis expected %0d got %0d", $time, exp.axis, m_axis_tuser);
          end
          if (m_axis_tdata !== exp.position) begin
            fail_count++;
            $display("%0t: position expected %h got %h",
                     $time, exp.position, m_axis_tdata);
          end
        end
      end
      if (long_hold_asks != long_holds_done) begin
        long_holds_done++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_gap_odds != 0 && $urandom_range(1, sink_gap_odds) == 1)
          sink_gap = $urandom_range(1, 11);
      end
    end
  end

  // one register write beat, meant only for while the parser is idle; the task itself does not check that
  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTiltId) tilt_id = val;
    else pan_id = val;
  endtask

  // full status packet; the first two parameters carry the position
  task automatic queue_packet(input logic [7:0] id, input logic [7:0] len,
                              input logic [15:0] pos);
    int n;
    n = (len >= 8'd2) ? int'(len) - 2 : 0;
    rx_byte_q.push_back(SyncByte);
    rx_byte_q.push_back(SyncByte);
    rx_byte_q.push_back(id);
    rx_byte_q.push_back(len);
    rx_byte_q.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < n; k++) begin
      if (k == 0) rx_byte_q.push_back(pos[7:0]);
      else if (k == 1) rx_byte_q.push_back(pos[15:8]);
      else rx_byte_q.push_back(8'($urandom_range(0, 255)));
    end
    rx_byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed packets, some line noise and broken openings
  task automatic queue_random_traffic(input int budget);
    int start;
    int pick;
    int noise;
    logic [7:0] id;
    logic [7:0] len;
    start = rx_byte_q.size();
    while (rx_byte_q.size() - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        pick = $urandom_range(0, 9);
        id = (pick < 4) ? tilt_id : (pick < 8) ? pan_id : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick == 0) len = 8'hFF;
        else if (pick < 3) len = 8'($urandom_range(0, 255));
        else if (pick < 10) len = 8'($urandom_range(0, 3));
        else len = 8'($urandom_range(2, 6));
        queue_packet(id, len, 16'($urandom_range(0, 65535)));
      end else if (pick == 8) begin
        noise = $urandom_range(1, 4);
        repeat (noise) rx_byte_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // sync byte followed by something else
        rx_byte_q.push_back(SyncByte);
        rx_byte_q.push_back(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // wait for every byte and report, then let the pipeline settle
  task automatic drain();
    int w;
    do @(posedge clk_i); while (rx_byte_q.size() != 0 || s_axis_tvalid);
    for (w = 0; w < 5000 && pending_reports_q.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_reports_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d reports expected, none arrived; first axis %0d position %h",
               $time, pending_reports_q.size(), pending_reports_q[0].axis,
               pending_reports_q[0].position);
      pending_reports_q.delete();
    end
  endtask

  // stimulus: directed packets at reset ids, then phases of random traffic
  initial begin
    logic [7:0] new_tilt;
    logic [7:0] new_pan;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // broken opening, tilt at full scale, then a pan and a tilt packet too short to report
    src_gap_odds  = 5;
    sink_gap_odds = 5;
    rx_byte_q.push_back(SyncByte);
    rx_byte_q.push_back(8'h00);
    queue_packet(TiltIdReset, 8'd4, 16'hFFFF);
    queue_packet(PanIdReset, 8'd2, 16'h0000);
    queue_packet(TiltIdReset, 8'd1, 16'h0000);
    // extra sync byte read as the id
    queue_packet(SyncByte, 8'd3, 16'h0000);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin new_tilt = 8'd0;   new_pan = 8'd253; end
        1: begin new_tilt = 8'd253; new_pan = 8'd0;   end
        2: begin new_tilt = 8'd7;   new_pan = 8'd7;   end
        3: begin new_tilt = 8'd255; new_pan = 8'd128; end
        6: begin new_tilt = TiltIdReset; new_pan = PanIdReset; end
        default: begin
          new_tilt = 8'($urandom_range(0, 253));
          new_pan  = 8'($urandom_range(0, 253));
        end
      endcase
      write_reg(CfgTiltId, new_tilt);
      write_reg(CfgPanId, new_pan);
      id_settings++;
      case (p)
        0: begin src_gap_odds = 3;  sink_gap_odds = 3;  end
        1: begin src_gap_odds = 0;  sink_gap_odds = 0;  end
        2: begin src_gap_odds = 6;  sink_gap_odds = 2;  end
        3: begin src_gap_odds = 2;  sink_gap_odds = 6;  end
        4: begin src_gap_odds = 4;  sink_gap_odds = 4;  end
        5: begin src_gap_odds = 10; sink_gap_odds = 10; end
        default: begin src_gap_odds = 0; sink_gap_odds = 0; end
      endcase
      // receiver holds off while the sender keeps pushing
      if (p == 1) long_hold_asks++;
      queue_random_traffic(200);
      drain();
    end

    $display("sent %0d bytes over %0d id settings plus reset ids", bytes_taken, id_settings);
    $display("checked %0d position reports, %0d tilt and %0d pan",
             reports_seen, tilt_reports, reports_seen - tilt_reports);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
